// File: sv/rrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and codes for the round-robin slice scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned CmdW       = 2;
  localparam int unsigned IdW        = 8;
  localparam int unsigned InBurstW   = 12;
  localparam int unsigned QuantumW   = 12;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned LenW       = 12;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 72;
  localparam int unsigned OutUserW   = 4;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [QuantumW-1:0] QuantumReset = 12'd4;
  localparam logic                RegQuantum   = 1'b0;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_SLICE   = 3'd2,
    ST_DONE    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_GRANT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic    latch;
    logic    load_wr;
    logic    clear;
    logic    scan_init;
    logic    mod_sub;
    logic    rd;
    logic    advance;
    logic    grant;
    logic    res_set;
    status_e res_status;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            full;
    logic            empty;
    logic            mod_ge;
    logic            scan_last;
    logic            rem_nz;
    logic            out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/round_robin_slice_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_top
// Round-robin time-slice scheduler with an APB quantum register.
// ----------------------------------------------------------------------------
// One item is taken at a time. Load and clear items, and a next-slice item on
// an empty table, go from decode straight to the result stage, which waits
// for the output register to empty. Any other next-slice item first folds
// the saved pointer into the table size by repeated subtracts, then examines
// entries in table order from there, each needing one registered read of the
// process table and one check, with a grant step when a slice is granted.
// The result is held in an output register until taken; the next item is
// accepted once the result has moved there.
module round_robin_slice_scheduler_top #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned BURST_BITS    = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // process_id [7:0], burst_time [19:8]
  input  wire logic [rrs_pkg::InDataW-1:0]   s_axis_tdata,
  // cmd [1:0]
  input  wire logic [rrs_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // slice_process [7:0], slice_length [19:8], slice_end_time [35:20],
  // waiting_time [51:36], turnaround_time [67:52]
  output logic [rrs_pkg::OutDataW-1:0]       m_axis_tdata,
  // status [2:0], finished [3]
  output logic [rrs_pkg::OutUserW-1:0]       m_axis_tuser,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrs_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [rrs_pkg::ApbDataW-1:0]  pwdata,
  output logic [rrs_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);

  logic [rrs_pkg::QuantumW-1:0] quantum_q;
  logic                         sel_quantum;
  rrs_pkg::ctl_t                ctl;
  rrs_pkg::stat_t               stat;

  assign pready      = 1'b1;
  assign sel_quantum = (paddr[2] == rrs_pkg::RegQuantum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrs_pkg::QuantumReset;
    end else if (psel && penable && pwrite && pready && sel_quantum) begin
      quantum_q <= pwdata[rrs_pkg::QuantumW-1:0];
    end
  end

  assign prdata = sel_quantum ? rrs_pkg::ApbDataW'(quantum_q) : '0;

  rrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  rrs_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .BURST_BITS    (BURST_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .quantum_i  (quantum_q),
    .m_tready_i (m_axis_tready),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// File: sv/rrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer: decodes the command, steps the table scan and hands off results.
// ----------------------------------------------------------------------------
module rrs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire rrs_pkg::stat_t stat_i,
  output rrs_pkg::ctl_t      ctl_o
);

  rrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    ctl_o.res_status = rrs_pkg::ST_LOADED;
    s_ready_o = 1'b0;
    case (state_q)
      rrs_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = rrs_pkg::S_DECODE;
        end
      end
      rrs_pkg::S_DECODE: begin
        ctl_o.res_set = 1'b1;
        state_d       = rrs_pkg::S_RESULT;
        case (stat_i.cmd)
          rrs_pkg::CMD_LOAD: begin
            if (stat_i.full) begin
              ctl_o.res_status = rrs_pkg::ST_FULL;
            end else begin
              ctl_o.load_wr    = 1'b1;
              ctl_o.res_status = rrs_pkg::ST_LOADED;
            end
          end
          rrs_pkg::CMD_NEXT: begin
            if (stat_i.empty) begin
              ctl_o.res_status = rrs_pkg::ST_DONE;
            end else begin
              ctl_o.res_set   = 1'b0;
              ctl_o.scan_init = 1'b1;
              state_d         = rrs_pkg::S_MOD;
            end
          end
          default: begin
            ctl_o.clear      = 1'b1;
            ctl_o.res_status = rrs_pkg::ST_CLEARED;
          end
        endcase
      end
      rrs_pkg::S_MOD: begin
        if (stat_i.mod_ge) begin
          ctl_o.mod_sub = 1'b1;
        end else begin
          state_d = rrs_pkg::S_READ;
        end
      end
      rrs_pkg::S_READ: begin
        ctl_o.rd = 1'b1;
        state_d  = rrs_pkg::S_CHECK;
      end
      rrs_pkg::S_CHECK: begin
        if (stat_i.rem_nz) begin
          state_d = rrs_pkg::S_GRANT;
        end else if (stat_i.scan_last) begin
          ctl_o.res_set    = 1'b1;
          ctl_o.res_status = rrs_pkg::ST_DONE;
          state_d          = rrs_pkg::S_RESULT;
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = rrs_pkg::S_READ;
        end
      end
      rrs_pkg::S_GRANT: begin
        ctl_o.grant      = 1'b1;
        ctl_o.res_set    = 1'b1;
        ctl_o.res_status = rrs_pkg::ST_SLICE;
        state_d          = rrs_pkg::S_RESULT;
      end
      rrs_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = rrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rrs_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/rrs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_dp
// Process table, scan index, clock and result registers.
// ----------------------------------------------------------------------------
module rrs_dp #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned BURST_BITS    = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // process_id [7:0], burst_time [19:8]
  input  wire logic [rrs_pkg::InDataW-1:0]     s_tdata_i,
  // cmd [1:0]
  input  wire logic [rrs_pkg::InUserW-1:0]     s_tuser_i,
  input  wire logic [rrs_pkg::QuantumW-1:0]    quantum_i,
  input  wire logic                            m_tready_i,
  input  wire rrs_pkg::ctl_t                   ctl_i,
  output rrs_pkg::stat_t                       stat_o,
  output logic                                 m_tvalid_o,
  // slice_process [7:0], slice_length [19:8], slice_end_time [35:20],
  // waiting_time [51:36], turnaround_time [67:52]
  output logic [rrs_pkg::OutDataW-1:0]         m_tdata_o,
  // status [2:0], finished [3]
  output logic [rrs_pkg::OutUserW-1:0]         m_tuser_o
);

  localparam int unsigned IdxW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned CmpW = (BURST_BITS > rrs_pkg::QuantumW) ?
                                 BURST_BITS : rrs_pkg::QuantumW;
  localparam int unsigned BtW  = (BURST_BITS > rrs_pkg::TimeW) ?
                                 BURST_BITS : rrs_pkg::TimeW;
  localparam int unsigned PadW = rrs_pkg::OutDataW - rrs_pkg::IdW - rrs_pkg::LenW
                                 - 3 * rrs_pkg::TimeW;

  logic [rrs_pkg::IdW-1:0]      ids_mem    [MAX_PROCESSES];
  logic [BURST_BITS-1:0]        bursts_mem [MAX_PROCESSES];
  logic [BURST_BITS-1:0]        rem_mem    [MAX_PROCESSES];

  logic [rrs_pkg::CmdW-1:0]     cmd_q;
  logic [rrs_pkg::IdW-1:0]      pid_q;
  logic [rrs_pkg::InBurstW-1:0] burst_q;
  logic [CntW-1:0]              count_q;
  logic [IdxW-1:0]              np_q;
  logic [rrs_pkg::TimeW-1:0]    clock_q, clock_d;
  logic [CntW-1:0]              k_q, i_q;
  logic [rrs_pkg::IdW-1:0]      rd_id_q;
  logic [BURST_BITS-1:0]        rd_burst_q, rd_rem_q;

  rrs_pkg::status_e             res_status_q;
  logic [rrs_pkg::IdW-1:0]      res_pid_q;
  logic [rrs_pkg::LenW-1:0]     res_len_q;
  logic [rrs_pkg::TimeW-1:0]    res_end_q, res_wait_q, res_tat_q;
  logic                         res_fin_q;

  logic                         out_valid_q;
  rrs_pkg::status_e             out_status_q;
  logic [rrs_pkg::IdW-1:0]      out_pid_q;
  logic [rrs_pkg::LenW-1:0]     out_len_q;
  logic [rrs_pkg::TimeW-1:0]    out_end_q, out_wait_q, out_tat_q;
  logic                         out_fin_q;

  logic [CmpW-1:0]              q_ext, rem_ext, grant_ext, new_rem_ext, in_burst_ext;
  logic [rrs_pkg::LenW-1:0]     grant;
  logic [BURST_BITS-1:0]        new_rem;
  logic [BtW-1:0]               burst_t_ext;
  logic [rrs_pkg::TimeW-1:0]    wait_d;
  logic [IdxW-1:0]              k_idx, load_idx, np_d;
  logic [CntW-1:0]              k_inc;

  assign k_idx    = k_q[IdxW-1:0];
  assign load_idx = count_q[IdxW-1:0];
  assign k_inc    = k_q + CntW'(1);

  always_comb begin
    q_ext        = (quantum_i == '0) ? CmpW'(1) : CmpW'(quantum_i);
    rem_ext      = CmpW'(rd_rem_q);
    grant_ext    = (rem_ext < q_ext) ? rem_ext : q_ext;
    grant        = grant_ext[rrs_pkg::LenW-1:0];
    new_rem_ext  = rem_ext - grant_ext;
    new_rem      = new_rem_ext[BURST_BITS-1:0];
    in_burst_ext = CmpW'(burst_q);
    clock_d      = clock_q + rrs_pkg::TimeW'(grant);
    burst_t_ext  = BtW'(rd_burst_q);
    wait_d       = clock_d - burst_t_ext[rrs_pkg::TimeW-1:0];
    np_d         = (k_idx == IdxW'(MAX_PROCESSES - 1)) ? '0 : k_idx + IdxW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_wr) begin
      ids_mem[load_idx]    <= pid_q;
      bursts_mem[load_idx] <= in_burst_ext[BURST_BITS-1:0];
    end
    if (ctl_i.load_wr) begin
      rem_mem[load_idx] <= in_burst_ext[BURST_BITS-1:0];
    end else if (ctl_i.grant) begin
      rem_mem[k_idx] <= new_rem;
    end
    if (ctl_i.rd) begin
      rd_id_q    <= ids_mem[k_idx];
      rd_burst_q <= bursts_mem[k_idx];
      rd_rem_q   <= rem_mem[k_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= s_tuser_i;
      pid_q   <= s_tdata_i[rrs_pkg::IdW-1:0];
      burst_q <= s_tdata_i[rrs_pkg::IdW +: rrs_pkg::InBurstW];
    end
    if (ctl_i.res_set) begin
      res_status_q <= ctl_i.res_status;
      if (ctl_i.grant) begin
        res_pid_q  <= rd_id_q;
        res_len_q  <= grant;
        res_end_q  <= clock_d;
        res_fin_q  <= (new_rem == '0);
        res_wait_q <= (new_rem == '0) ? wait_d : '0;
        res_tat_q  <= (new_rem == '0) ? clock_d : '0;
      end else begin
        res_pid_q  <= '0;
        res_len_q  <= '0;
        res_end_q  <= '0;
        res_fin_q  <= 1'b0;
        res_wait_q <= '0;
        res_tat_q  <= '0;
      end
    end
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_pid_q    <= res_pid_q;
      out_len_q    <= res_len_q;
      out_end_q    <= res_end_q;
      out_fin_q    <= res_fin_q;
      out_wait_q   <= res_wait_q;
      out_tat_q    <= res_tat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      np_q        <= '0;
      clock_q     <= '0;
      k_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        count_q <= '0;
        np_q    <= '0;
        clock_q <= '0;
      end else if (ctl_i.load_wr) begin
        count_q <= count_q + CntW'(1);
      end else if (ctl_i.grant) begin
        clock_q <= clock_d;
        np_q    <= np_d;
      end
      if (ctl_i.scan_init) begin
        k_q <= CntW'(np_q);
        i_q <= '0;
      end else if (ctl_i.mod_sub) begin
        k_q <= k_q - count_q;
      end else if (ctl_i.advance) begin
        k_q <= (k_inc == count_q) ? '0 : k_inc;
        i_q <= i_q + CntW'(1);
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.full      = (count_q >= CntW'(MAX_PROCESSES));
    stat_o.empty     = (count_q == '0);
    stat_o.mod_ge    = (k_q >= count_q);
    stat_o.scan_last = ((i_q + CntW'(1)) == count_q);
    stat_o.rem_nz    = (rd_rem_q != '0);
    stat_o.out_free  = !out_valid_q || m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{PadW{1'b0}}, out_tat_q, out_wait_q, out_end_q, out_len_q, out_pid_q};
  assign m_tuser_o  = {out_fin_q, out_status_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PROCESSES))
    else $error("table count beyond capacity");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rd |-> (k_q < count_q))
    else $error("scan reads outside the loaded table");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten before it was taken");

  a_finished_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fin_q) |-> (out_status_q == rrs_pkg::ST_SLICE))
    else $error("finished flag on a non-slice result");

endmodule
`default_nettype wire

// File: sim/rrs_slice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_slice_checker
// Watches the item, result and APB channels of the round-robin slice
// scheduler and keeps its own copy of the process table, clock and quantum.
// Every accepted item yields one expected result. Each accepted result is
// checked field by field against the oldest one. Quantum read-back is also
// checked. The number of failures and of outstanding results go to the top.
// ----------------------------------------------------------------------------
module rrs_slice_checker
  import rrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_tvalid_i,
  input  logic                in_tready_i,
  input  logic [InDataW-1:0]  in_tdata_i,
  input  logic [InUserW-1:0]  in_tuser_i,
  input  logic                out_tvalid_i,
  input  logic                out_tready_i,
  input  logic [OutDataW-1:0] out_tdata_i,
  input  logic [OutUserW-1:0] out_tuser_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic [ApbDataW-1:0] prdata_i,
  input  logic                pready_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned Slots = 16;
  localparam logic [ApbAddrW-1:0] QuantumAddr = ApbAddrW'(4 * RegQuantum);

  typedef struct packed {
    status_e            status;
    logic [IdW-1:0]     proc;
    logic [LenW-1:0]    len;
    logic [TimeW-1:0]   end_t;
    logic               fin;
    logic [TimeW-1:0]   wait_t;
    logic [TimeW-1:0]   tat;
  } slice_rec_t;

  logic [IdW-1:0]      slot_id    [Slots];
  logic [InBurstW-1:0] slot_burst [Slots];
  logic [InBurstW-1:0] slot_left  [Slots];
  logic [4:0]          slot_count;
  logic [3:0]          serve_ptr;
  logic [TimeW-1:0]    sched_clock;
  logic [QuantumW-1:0] quantum_q;

  slice_rec_t slice_expect_q [$];

  function automatic slice_rec_t schedule_item(logic [CmdW-1:0] cmd, logic [IdW-1:0] pid,
                                               logic [InBurstW-1:0] burst);
    slice_rec_t      r;
    logic            found;
    logic [3:0]      sel;
    logic [LenW-1:0] q;
    logic [LenW-1:0] grant;
    int              slot;
    r = '0;
    found = 1'b0;
    sel = '0;
    case (cmd_e'(cmd))
      CMD_LOAD: begin
        if (slot_count >= Slots) begin
          r.status = ST_FULL;
        end else begin
          slot_id[slot_count[3:0]]    = pid;
          slot_burst[slot_count[3:0]] = burst;
          slot_left[slot_count[3:0]]  = burst;
          slot_count = slot_count + 5'd1;
          r.status = ST_LOADED;
        end
      end
      CMD_NEXT: begin
        for (int i = 0; i < int'(slot_count) && !found; i++) begin
          slot = (int'(serve_ptr) + i) % int'(slot_count);
          if (slot_left[slot] != '0) begin
            sel = slot[3:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_DONE;
        end else begin
          q = (quantum_q == '0) ? LenW'(1) : quantum_q;
          grant = (slot_left[sel] < q) ? slot_left[sel] : q;
          slot_left[sel] = slot_left[sel] - grant;
          sched_clock = sched_clock + {4'b0, grant};
          serve_ptr = sel + 4'd1;
          r.status = ST_SLICE;
          r.proc   = slot_id[sel];
          r.len    = grant;
          r.end_t  = sched_clock;
          if (slot_left[sel] == '0) begin
            r.fin    = 1'b1;
            r.wait_t = sched_clock - {4'b0, slot_burst[sel]};
            r.tat    = sched_clock;
          end
        end
      end
      default: begin
        slot_count = '0;
        serve_ptr = '0;
        sched_clock = '0;
        r.status = ST_CLEARED;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slice_rec_t want;
    if (!rst_ni) begin
      quantum_q = QuantumReset;
      slot_count = '0;
      serve_ptr = '0;
      sched_clock = '0;
      slice_expect_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_tvalid_i && out_tready_i) begin
        if (slice_expect_q.size() == 0) begin
          $display("%0t: result with none expected, status %0d", $time, out_tuser_i[2:0]);
          fail_count_o++;
        end else begin
          want = slice_expect_q.pop_front();
          check_field("status", TimeW'(want.status), TimeW'(out_tuser_i[2:0]));
          check_field("slice_process", TimeW'(want.proc), TimeW'(out_tdata_i[7:0]));
          check_field("slice_length", TimeW'(want.len), TimeW'(out_tdata_i[19:8]));
          check_field("slice_end_time", want.end_t, out_tdata_i[35:20]);
          check_field("finished", TimeW'(want.fin), TimeW'(out_tuser_i[3]));
          check_field("waiting_time", want.wait_t, out_tdata_i[51:36]);
          check_field("turnaround_time", want.tat, out_tdata_i[67:52]);
        end
      end
      if (in_tvalid_i && in_tready_i) begin
        slice_expect_q.push_back(schedule_item(in_tuser_i[CmdW-1:0], in_tdata_i[7:0],
                                               in_tdata_i[19:8]));
      end
      if (psel_i && penable_i && pready_i && paddr_i == QuantumAddr) begin
        if (pwrite_i) begin
          quantum_q = pwdata_i[QuantumW-1:0];
        end else if (prdata_i !== ApbDataW'(quantum_q)) begin
          $display("%0t: quantum read mismatch, expected %0d, actual %0d", $time,
                   quantum_q, prdata_i);
          fail_count_o++;
        end
      end
      pending_o = slice_expect_q.size();
    end
  end

endmodule

// File: sim/tb_round_robin_slice_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_slice_scheduler_top
// Regression for the round-robin slice scheduler. A directed part covers
// an empty table, zero bursts, zero and maximum quantum, the spare
// command and clears. Random sessions of clear, loads and slice requests
// follow under several quantum values and idle patterns, with one long
// result-side hold-off. Checking is done by rrs_slice_checker.
// ----------------------------------------------------------------------------
module tb_round_robin_slice_scheduler_top;
  import rrs_pkg::*;

  localparam int unsigned    RandomItems  = 1230;
  localparam int unsigned    Phases       = 6;
  localparam int unsigned    SettleCycles = 64;
  localparam int unsigned    RxHoldCycles = 400;
  localparam logic [CmdW-1:0] CmdSpare    = 2'd3;
  localparam logic [ApbAddrW-1:0] QuantumAddr = ApbAddrW'(4 * RegQuantum);

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  int   cur_qe;
  logic rx_hold_req;

  round_robin_slice_scheduler_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rrs_slice_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tuser_i  (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(64'd8_000_000);
    $display("round_robin_slice_scheduler_top regression: fail");
    $finish;
  end

  // Result side: random idling, or a long hold-off on request.
  initial begin
    int held;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (held = 0; held < RxHoldCycles; held++) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  task automatic push_item(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] pid,
                           input logic [InBurstW-1:0] burst);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, burst, pid};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_quantum(input logic [QuantumW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= QuantumAddr;
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    cur_qe = (value == '0) ? 1 : int'(value);
  endtask

  function automatic logic [InBurstW-1:0] pick_burst();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return '0;
    if (r < 15 && cur_qe >= 256) return InBurstW'($urandom());
    return InBurstW'($urandom_range((3 * cur_qe > 4095) ? 4095 : 3 * cur_qe, 1));
  endfunction

  // One session: clear, load entries, then request enough slices to finish them.
  task automatic run_session();
    int                  n;
    int                  r;
    int                  slices;
    logic [InBurstW-1:0] burst;
    r = $urandom_range(99, 0);
    n = (r < 8) ? 0 : (r < 22) ? $urandom_range(18, 16) : $urandom_range(8, 1);
    push_item($urandom_range(1, 0) ? CMD_CLEAR : CmdSpare, IdW'($urandom()),
              InBurstW'($urandom()));
    slices = $urandom_range(2, 0);
    for (int e = 0; e < n; e++) begin
      burst = pick_burst();
      push_item(CMD_LOAD, IdW'($urandom()), burst);
      if (e < 16) slices += (int'(burst) + cur_qe - 1) / cur_qe;
    end
    for (int s = 0; s < slices; s++) begin
      if ($urandom_range(99, 0) < 8) begin
        push_item(CmdW'($urandom()), IdW'($urandom()), pick_burst());
      end else begin
        push_item(CMD_NEXT, IdW'($urandom()), InBurstW'($urandom()));
      end
    end
  endtask

  initial begin
    logic [QuantumW-1:0] q;
    int                  target;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_hold_req   = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 77;
    items_sent    = 0;
    cur_qe        = int'(QuantumReset);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset quantum: empty table, zero burst, wrap of the scan, spare command.
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_LOAD, 8'h00, 12'h000);
    push_item(CMD_LOAD, 8'hFF, 12'hFFF);
    push_item(CMD_LOAD, 8'h5A, 12'h001);
    push_item(CMD_NEXT, 8'hFF, 12'hFFF);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CmdSpare, 8'hFF, 12'hFFF);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    drain_results();

    // Zero quantum acts as one.
    write_quantum(12'd0);
    push_item(CMD_LOAD, 8'h12, 12'd2);
    push_item(CMD_LOAD, 8'h34, 12'd1);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_CLEAR, 8'h00, 12'h000);
    drain_results();

    // Largest quantum against the largest burst.
    write_quantum(12'hFFF);
    push_item(CMD_LOAD, 8'hC3, 12'hFFF);
    push_item(CMD_LOAD, 8'h3C, 12'd7);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_NEXT, 8'h00, 12'h000);
    push_item(CMD_NEXT, 8'h00, 12'h000);

    for (int ph = 0; ph < Phases; ph++) begin
      drain_results();
      case (ph)
        0:       q = 12'd1;
        1:       q = QuantumW'($urandom_range(64, 2));
        2:       q = 12'hFFF;
        3:       q = 12'd2;
        4:       q = QuantumW'($urandom_range(4095, 1));
        default: q = 12'd3;
      endcase
      write_quantum(q);
      send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 77 : 0;
      recv_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 21 : 0;
      if (ph == 4) rx_hold_req <= 1'b1;
      target = items_sent + RandomItems / Phases;
      while (items_sent < target) run_session();
    end

    drain_results();
    if (fail_count == 0) begin
      $display("round_robin_slice_scheduler_top regression: pass");
    end else begin
      $display("round_robin_slice_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule

// File: round_robin_slice_scheduler_top.f
sv/rrs_pkg.sv
sv/rrs_ctrl.sv
sv/rrs_dp.sv
sv/round_robin_slice_scheduler_top.sv
sim/rrs_slice_checker.sv
sim/tb_round_robin_slice_scheduler_top.sv
